// ===== rtl/jccs_pkg.sv =====
// ----------------------------------------------------------------------------
// jccs_pkg
// Shared constants, byte codes and controller/datapath interface types for
// the jsonc comment and trailing comma stripper.
// ----------------------------------------------------------------------------
package jccs_pkg;

    // default number of whitespace bytes held behind a comma
    localparam int HOLD_DEPTH_DEF = 16;

    // character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // lexer modes
    localparam logic [2:0] MODE_TEXT  = 3'd0;
    localparam logic [2:0] MODE_SLASH = 3'd1;
    localparam logic [2:0] MODE_LINE  = 3'd2;
    localparam logic [2:0] MODE_BLOCK = 3'd3;
    localparam logic [2:0] MODE_STAR  = 3'd4;
    localparam logic [2:0] MODE_STR   = 3'd5;
    localparam logic [2:0] MODE_ESC   = 3'd6;

    // source of an emitted byte
    localparam logic [1:0] SRC_HEAD  = 2'd0;
    localparam logic [1:0] SRC_COMMA = 2'd1;
    localparam logic [1:0] SRC_STORE = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;        // take the input item, run the lexer
        logic       pop;         // drop the head pending byte
        logic       hold_comma;  // start holding a comma
        logic       store_space; // append head byte to whitespace store
        logic       emit;        // emit one byte
        logic [1:0] emit_src;    // which byte to emit
        logic       idx_inc;     // advance release index
        logic       rel_done;    // release finished, clear held comma
        logic       flush;       // close the item on the output side
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic head_valid;
        logic head_space;
        logic head_close;
        logic head_comma;
        logic held;
        logic cnt_full;
        logic idx_done;
        logic last;
        logic emit_ok;
        logic flush_ok;
    } status_t;

endpackage

// ===== rtl/jccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// jccs_ctrl
// Controller state machine: steps pending bytes through the comma stage,
// sequences comma releases and closes each item.
// ----------------------------------------------------------------------------
module jccs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  jccs_pkg::status_t st,
    output jccs_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHAR   = 3'd1;
    localparam logic [2:0] S_RCOMMA = 3'd2;
    localparam logic [2:0] S_RSPACE = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (!st.head_valid)
                begin
                    if (st.last && st.held)
                    begin
                        state_next = S_RCOMMA;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else if (st.held)
                begin
                    if (st.head_space && !st.cnt_full)
                    begin
                        cmd.store_space = 1'b1;
                        cmd.pop = 1'b1;
                    end
                    else if (st.head_close)
                    begin
                        state_next = S_RSPACE;
                    end
                    else
                    begin
                        state_next = S_RCOMMA;
                    end
                end
                else if (st.head_comma)
                begin
                    cmd.hold_comma = 1'b1;
                    cmd.pop = 1'b1;
                end
                else if (st.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_src = jccs_pkg::SRC_HEAD;
                    cmd.pop = 1'b1;
                end
            end
            S_RCOMMA:
            begin
                if (st.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_src = jccs_pkg::SRC_COMMA;
                    state_next = S_RSPACE;
                end
            end
            S_RSPACE:
            begin
                if (st.idx_done)
                begin
                    cmd.rel_done = 1'b1;
                    state_next = S_CHAR;
                end
                else if (st.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_src = jccs_pkg::SRC_STORE;
                    cmd.idx_inc = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (st.flush_ok)
                begin
                    cmd.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/jccs_dp.sv =====
// ----------------------------------------------------------------------------
// jccs_dp
// Datapath: comment lexer, pending byte queue, held comma with whitespace
// store, one-byte lookahead for the end mark and the output register.
// ----------------------------------------------------------------------------
module jccs_dp
#(
    parameter int HOLD_DEPTH = jccs_pkg::HOLD_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  jccs_pkg::cmd_t    cmd,
    output jccs_pkg::status_t st,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_flag,
    output logic              out_last
);

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    logic [2:0]       mode_reg;
    logic             q0v_reg;
    logic [7:0]       q0_reg;
    logic             q1v_reg;
    logic [7:0]       q1_reg;
    logic             last_reg;
    logic             held_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [7:0]       store_reg [HOLD_DEPTH];
    logic             hv_reg;
    logic [7:0]       h_reg;
    logic             ov_reg;
    logic [7:0]       obyte_reg;
    logic             oflag_reg;
    logic             olast_reg;

    logic [2:0] mode_next;
    logic       c0v;
    logic [7:0] c0;
    logic       c1v;
    logic [7:0] c1;
    logic [7:0] emit_byte;
    logic       out_free;

    // lexer: bytes passed to the comma stage and the next mode
    always_comb
    begin
        c0v = 1'b0;
        c0 = in_byte;
        c1v = 1'b0;
        c1 = in_byte;
        mode_next = mode_reg;
        case (mode_reg)
            jccs_pkg::MODE_SLASH:
            begin
                if (in_byte == jccs_pkg::CH_SLASH)
                begin
                    mode_next = jccs_pkg::MODE_LINE;
                end
                else if (in_byte == jccs_pkg::CH_STAR)
                begin
                    mode_next = jccs_pkg::MODE_BLOCK;
                end
                else
                begin
                    c0v = 1'b1;
                    c0 = jccs_pkg::CH_SLASH;
                    c1v = 1'b1;
                    mode_next = (in_byte == jccs_pkg::CH_QUOTE) ? jccs_pkg::MODE_STR
                                                                : jccs_pkg::MODE_TEXT;
                end
            end
            jccs_pkg::MODE_LINE:
            begin
                if (in_byte == jccs_pkg::CH_NL)
                begin
                    c0v = 1'b1;
                    mode_next = jccs_pkg::MODE_TEXT;
                end
            end
            jccs_pkg::MODE_BLOCK:
            begin
                if (in_byte == jccs_pkg::CH_STAR)
                begin
                    mode_next = jccs_pkg::MODE_STAR;
                end
            end
            jccs_pkg::MODE_STAR:
            begin
                if (in_byte == jccs_pkg::CH_SLASH)
                begin
                    mode_next = jccs_pkg::MODE_TEXT;
                end
                else if (in_byte != jccs_pkg::CH_STAR)
                begin
                    mode_next = jccs_pkg::MODE_BLOCK;
                end
            end
            jccs_pkg::MODE_STR:
            begin
                c0v = 1'b1;
                if (in_byte == jccs_pkg::CH_BSL)
                begin
                    mode_next = jccs_pkg::MODE_ESC;
                end
                else if (in_byte == jccs_pkg::CH_QUOTE)
                begin
                    mode_next = jccs_pkg::MODE_TEXT;
                end
            end
            jccs_pkg::MODE_ESC:
            begin
                c0v = 1'b1;
                mode_next = jccs_pkg::MODE_STR;
            end
            default:
            begin
                if (in_byte == jccs_pkg::CH_SLASH)
                begin
                    mode_next = jccs_pkg::MODE_SLASH;
                end
                else
                begin
                    c0v = 1'b1;
                    mode_next = (in_byte == jccs_pkg::CH_QUOTE) ? jccs_pkg::MODE_STR
                                                                : jccs_pkg::MODE_TEXT;
                end
            end
        endcase
        // a slash still pending at end of text goes out as data
        if (in_last && (mode_next == jccs_pkg::MODE_SLASH))
        begin
            if (!c0v)
            begin
                c0v = 1'b1;
                c0 = jccs_pkg::CH_SLASH;
            end
            else
            begin
                c1v = 1'b1;
                c1 = jccs_pkg::CH_SLASH;
            end
        end
        if (in_last)
        begin
            mode_next = jccs_pkg::MODE_TEXT;
        end
    end

    // byte selection for emit
    always_comb
    begin
        case (cmd.emit_src)
            jccs_pkg::SRC_HEAD:  emit_byte = q0_reg;
            jccs_pkg::SRC_COMMA: emit_byte = jccs_pkg::CH_COMMA;
            jccs_pkg::SRC_STORE: emit_byte = store_reg[idx_reg[IDX_W-1:0]];
            default:             emit_byte = q0_reg;
        endcase
    end

    assign out_free = !ov_reg || out_ready;

    // status back to the controller
    always_comb
    begin
        st.head_valid = q0v_reg;
        st.head_space = (q0_reg == jccs_pkg::CH_SPACE) || (q0_reg == jccs_pkg::CH_TAB)
                     || (q0_reg == jccs_pkg::CH_CR) || (q0_reg == jccs_pkg::CH_NL);
        st.head_close = (q0_reg == jccs_pkg::CH_RBRACE) || (q0_reg == jccs_pkg::CH_RBRACK);
        st.head_comma = (q0_reg == jccs_pkg::CH_COMMA);
        st.held       = held_reg;
        st.cnt_full   = (cnt_reg == CNT_W'(HOLD_DEPTH));
        st.idx_done   = (idx_reg == cnt_reg);
        st.last       = last_reg;
        st.emit_ok    = !hv_reg || out_free;
        st.flush_ok   = out_free;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= jccs_pkg::MODE_TEXT;
            q0v_reg  <= 1'b0;
            q1v_reg  <= 1'b0;
            last_reg <= 1'b0;
            held_reg <= 1'b0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
            hv_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                mode_reg <= mode_next;
                q0v_reg  <= c0v;
                q1v_reg  <= c1v;
                last_reg <= in_last;
            end
            else if (cmd.pop)
            begin
                q0v_reg <= q1v_reg;
                q1v_reg <= 1'b0;
            end
            // held comma and its whitespace run
            if (cmd.hold_comma)
            begin
                held_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (cmd.store_space)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.rel_done)
            begin
                held_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            if (cmd.rel_done)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            // lookahead byte
            if (cmd.emit)
            begin
                hv_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hv_reg <= 1'b0;
            end
            // output register
            if ((cmd.emit && hv_reg) || (cmd.flush && (hv_reg || last_reg)))
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q0_reg <= c0;
            q1_reg <= c1;
        end
        else if (cmd.pop)
        begin
            q0_reg <= q1_reg;
        end
        if (cmd.store_space)
        begin
            store_reg[cnt_reg[IDX_W-1:0]] <= q0_reg;
        end
        if (cmd.emit)
        begin
            h_reg <= emit_byte;
            if (hv_reg)
            begin
                obyte_reg <= h_reg;
                oflag_reg <= 1'b1;
                olast_reg <= 1'b0;
            end
        end
        else if (cmd.flush)
        begin
            if (hv_reg)
            begin
                obyte_reg <= h_reg;
                oflag_reg <= 1'b1;
            end
            else
            begin
                obyte_reg <= '0;
                oflag_reg <= 1'b0;
            end
            olast_reg <= last_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = obyte_reg;
    assign out_flag  = oflag_reg;
    assign out_last  = olast_reg;

endmodule

// ===== rtl/jsonc_comment_comma_stripper_core.sv =====
// ----------------------------------------------------------------------------
// jsonc_comment_comma_stripper_core
// Strips comments and trailing commas from a JSONC byte stream.
// ----------------------------------------------------------------------------
// Input channel s_axis: one raw text byte per item in tdata[7:0], tlast marks
// the final byte of a text. Output channel m_axis: one cleaned byte per item
// in tdata[7:0], tuser set when the byte carries data (clear only on a bare
// end marker), tlast on the final item caused by the last input byte.
// Line and block comments are removed (a line comment keeps its newline),
// strings pass untouched, and a comma followed only by whitespace and then
// '}' or ']' is dropped. Up to HOLD_DEPTH whitespace bytes are held behind a
// comma; a longer run releases the comma and passes on.
// Items are worked one at a time: a new byte is accepted only once the last
// one has passed the lexer and the comma stage, any comma release it caused
// is done and its item is closed; the controller steps one byte per cycle
// while the output is not stalled. A byte waits in the lookahead register
// until the next emit or the flush moves it to the output register. Reset
// returns to normal text mode with no comma held. A stalled receiver holds
// the output register; the block then waits, losing nothing.
// ----------------------------------------------------------------------------
module jsonc_comment_comma_stripper_core
#(
    parameter int HOLD_DEPTH = jccs_pkg::HOLD_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tlast,  // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tuser,  // byte_valid
    output logic       m_axis_tlast   // end_of_text
);

    jccs_pkg::cmd_t    cmd;
    jccs_pkg::status_t st;

    // controller
    jccs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    jccs_dp
    #(
        .HOLD_DEPTH (HOLD_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_flag  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== tb/jccs_checker.sv =====
// ----------------------------------------------------------------------------
// jccs_checker
// Watches both stream channels of the jsonc comment and trailing comma
// stripper, predicts the cleaned bytes of every accepted text byte and
// compares each output item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module jccs_checker
#(
    parameter int HOLD_DEPTH = jccs_pkg::HOLD_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tlast,  // is_last
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,  // [7:0] out_byte
    input  logic       m_axis_tuser,  // byte_valid
    input  logic       m_axis_tlast,  // end_of_text
    output int         error_count,
    output int         outstanding
);

    import jccs_pkg::*;

    // most output items one text byte can cause
    localparam int MAX_RESULTS = 20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
    } clean_byte_t;

    clean_byte_t expected_bytes[$];

    // predictor state
    logic [2:0] lex_mode;
    logic       comma_held;
    int         space_count;
    logic [7:0] space_store [HOLD_DEPTH];
    int         item_results;

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL;
    endfunction

    function automatic void put_byte(logic [7:0] c);
        clean_byte_t entry;
        entry = '{out_byte: c, byte_valid: 1'b1, end_of_text: 1'b0};
        if (item_results < MAX_RESULTS)
        begin
            expected_bytes.push_back(entry);
            item_results++;
        end
    endfunction

    // let go of the held comma, with or without the comma itself
    function automatic void release_comma(bit keep);
        if (keep)
            put_byte(CH_COMMA);
        for (int i = 0; i < space_count && i < HOLD_DEPTH; i++)
            put_byte(space_store[i]);
        comma_held  = 1'b0;
        space_count = 0;
    endfunction

    // second stage: trailing comma removal, blind to strings
    function automatic void comma_stage(logic [7:0] c);
        if (comma_held)
        begin
            if (is_space(c))
            begin
                if (space_count < HOLD_DEPTH)
                begin
                    space_store[space_count] = c;
                    space_count++;
                end
                else
                begin
                    release_comma(1'b1);
                    put_byte(c);
                end
                return;
            end
            if (c == CH_RBRACE || c == CH_RBRACK)
            begin
                release_comma(1'b0);
                put_byte(c);
                return;
            end
            release_comma(1'b1);
        end
        if (c == CH_COMMA)
        begin
            comma_held  = 1'b1;
            space_count = 0;
        end
        else
            put_byte(c);
    endfunction

    function automatic void text_byte(logic [7:0] c);
        if (c == CH_QUOTE)
        begin
            lex_mode = MODE_STR;
            comma_stage(c);
        end
        else if (c == CH_SLASH)
            lex_mode = MODE_SLASH;
        else
        begin
            lex_mode = MODE_TEXT;
            comma_stage(c);
        end
    endfunction

    // first stage lexer, then end of text handling
    function automatic void strip_byte(logic [7:0] c, logic last);
        clean_byte_t tail;
        item_results = 0;
        case (lex_mode)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    lex_mode = MODE_LINE;
                else if (c == CH_STAR)
                    lex_mode = MODE_BLOCK;
                else
                begin
                    comma_stage(CH_SLASH);
                    text_byte(c);
                end
            end
            MODE_LINE:
            begin
                if (c == CH_NL)
                begin
                    lex_mode = MODE_TEXT;
                    comma_stage(c);
                end
            end
            MODE_BLOCK:
            begin
                if (c == CH_STAR)
                    lex_mode = MODE_STAR;
            end
            MODE_STAR:
            begin
                if (c == CH_SLASH)
                    lex_mode = MODE_TEXT;
                else if (c != CH_STAR)
                    lex_mode = MODE_BLOCK;
            end
            MODE_STR:
            begin
                comma_stage(c);
                if (c == CH_BSL)
                    lex_mode = MODE_ESC;
                else if (c == CH_QUOTE)
                    lex_mode = MODE_TEXT;
            end
            MODE_ESC:
            begin
                comma_stage(c);
                lex_mode = MODE_STR;
            end
            default:
                text_byte(c);
        endcase

        if (last)
        begin
            if (lex_mode == MODE_SLASH)
                comma_stage(CH_SLASH);
            if (comma_held)
                release_comma(1'b1);
            lex_mode    = MODE_TEXT;
            comma_held  = 1'b0;
            space_count = 0;
            if (item_results == 0)
                tail = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_text: 1'b1};
            else
            begin
                tail = expected_bytes.pop_back();
                tail.end_of_text = 1'b1;
            end
            expected_bytes.push_back(tail);
        end
    endfunction

    // compare output items, then predict from accepted input items
    always @(posedge clk or negedge rst_n)
    begin
        clean_byte_t want;
        int          errs;
        if (!rst_n)
        begin
            lex_mode    = MODE_TEXT;
            comma_held  = 1'b0;
            space_count = 0;
            expected_bytes.delete();
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected item: out_byte %h, byte_valid %b, end_of_text %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errs++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, m_axis_tdata);
                        errs++;
                    end
                    if (m_axis_tuser !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, actual %b",
                               want.byte_valid, m_axis_tuser);
                        errs++;
                    end
                    if (m_axis_tlast !== want.end_of_text)
                    begin
                        $error("end_of_text: expected %b, actual %b",
                               want.end_of_text, m_axis_tlast);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                strip_byte(s_axis_tdata, s_axis_tlast);
            error_count <= error_count + errs;
            outstanding <= expected_bytes.size();
        end
    end

endmodule

// ===== tb/tb_jsonc_comment_comma_stripper_core.sv =====
// ----------------------------------------------------------------------------
// tb_jsonc_comment_comma_stripper_core
// Feeds short directed texts and then randomly built JSONC fragments
// (trailing commas with short and overlong whitespace runs, comments,
// strings with escapes, lone slashes and raw noise) into the stripper with
// random gaps and back-pressure; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_jsonc_comment_comma_stripper_core;

    import jccs_pkg::*;

    localparam int HOLD_DEPTH  = HOLD_DEPTH_DEF;
    localparam int ITEMS_TOTAL = 25 + 325;
    localparam int STALL_LIMIT = 2000;

    typedef enum int {
        FRAG_TRAIL_COMMA,
        FRAG_LINE_NOTE,
        FRAG_BLOCK_NOTE,
        FRAG_STRING,
        FRAG_LONE_SLASH,
        FRAG_COMMA_RUN,
        FRAG_NOISE
    } frag_kind_t;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;   // is_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tuser;           // byte_valid
    logic       m_axis_tlast;           // end_of_text

    int         error_count;
    int         outstanding;
    int         items_sent    = 0;
    int         tx_idle_pct   = 30;
    int         rx_idle_pct   = 30;
    int         stall_cycles  = 0;
    bit         mid_drain_done = 1'b0;
    logic [7:0] text_run[$];

    jsonc_comment_comma_stripper_core #(.HOLD_DEPTH(HOLD_DEPTH)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    jccs_checker #(.HOLD_DEPTH(HOLD_DEPTH)) strip_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // random back-pressure on the output side
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** jsonc_comment_comma_stripper_core: FAILED **");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // one text byte, after a random gap; valid stays high afterwards
    task automatic send_item(logic [7:0] b, logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // hold off until every predicted item has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_NL;
        endcase
    endfunction

    // printable, but never a quote, backslash, slash or star
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(32, 126));
        while (b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_STAR);
        return b;
    endfunction

    task automatic build_fragment();
        frag_kind_t kind;
        int         n;
        int         pick;
        text_run.delete();
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2: kind = FRAG_TRAIL_COMMA;
            3:       kind = FRAG_LINE_NOTE;
            4:       kind = FRAG_BLOCK_NOTE;
            5:       kind = FRAG_STRING;
            6:       kind = FRAG_LONE_SLASH;
            7:       kind = FRAG_COMMA_RUN;
            default: kind = FRAG_NOISE;
        endcase
        case (kind)
            FRAG_TRAIL_COMMA:
            begin
                text_run.push_back(CH_COMMA);
                // now and then a run just short of, at or past the store depth
                n = ($urandom_range(7) == 0) ? $urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 3)
                                             : $urandom_range(4);
                for (int i = 0; i < n; i++)
                    text_run.push_back(ws_byte());
                // a block comment between comma and closer is invisible
                if ($urandom_range(3) == 0)
                begin
                    text_run.push_back(CH_SLASH);
                    text_run.push_back(CH_STAR);
                    text_run.push_back(plain_byte());
                    text_run.push_back(CH_STAR);
                    text_run.push_back(CH_SLASH);
                    text_run.push_back(ws_byte());
                end
                case ($urandom_range(3))
                    0:       text_run.push_back(CH_RBRACE);
                    1:       text_run.push_back(CH_RBRACK);
                    default: text_run.push_back(plain_byte());
                endcase
            end
            FRAG_LINE_NOTE:
            begin
                text_run.push_back(CH_SLASH);
                text_run.push_back(CH_SLASH);
                n = $urandom_range(5);
                for (int i = 0; i < n; i++)
                    text_run.push_back(plain_byte());
                text_run.push_back(CH_NL);
            end
            FRAG_BLOCK_NOTE:
            begin
                text_run.push_back(CH_SLASH);
                text_run.push_back(CH_STAR);
                n = $urandom_range(5);
                for (int i = 0; i < n; i++)
                    text_run.push_back(($urandom_range(2) == 0) ? CH_STAR : plain_byte());
                text_run.push_back(CH_STAR);
                text_run.push_back(CH_SLASH);
            end
            FRAG_STRING:
            begin
                text_run.push_back(CH_QUOTE);
                n = $urandom_range(5);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        text_run.push_back(CH_BSL);
                        case ($urandom_range(2))
                            0:       text_run.push_back(CH_QUOTE);
                            1:       text_run.push_back(CH_BSL);
                            default: text_run.push_back(CH_SLASH);
                        endcase
                    end
                    else if ($urandom_range(4) == 0)
                        text_run.push_back(CH_COMMA);
                    else
                        text_run.push_back(plain_byte());
                end
                text_run.push_back(CH_QUOTE);
            end
            FRAG_LONE_SLASH:
            begin
                text_run.push_back(CH_SLASH);
                case ($urandom_range(2))
                    0:       text_run.push_back(CH_QUOTE);
                    1:       text_run.push_back(CH_COMMA);
                    default: text_run.push_back(plain_byte());
                endcase
            end
            FRAG_COMMA_RUN:
            begin
                text_run.push_back(CH_COMMA);
                text_run.push_back(ws_byte());
                text_run.push_back(CH_COMMA);
                if ($urandom_range(1) == 0)
                    text_run.push_back(ws_byte());
                text_run.push_back(($urandom_range(1) == 0) ? CH_RBRACK : CH_RBRACE);
            end
            default:
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    text_run.push_back(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic send_run(logic last);
        for (int i = 0; i < text_run.size(); i++)
            send_item(text_run[i], last && (i == text_run.size() - 1));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte extremes, the second one closing the text
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        // text ending inside a line comment gives a bare end marker
        send_item(CH_SLASH, 1'b0);
        send_item(CH_SLASH, 1'b0);
        send_item(8'h61, 1'b1);
        // empty block comment closed through a star run
        send_item(CH_SLASH, 1'b0);
        send_item(CH_STAR, 1'b0);
        send_item(CH_STAR, 1'b0);
        send_item(CH_SLASH, 1'b0);
        send_item(8'h71, 1'b1);
        // string with escaped quote and a comma inside
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_BSL, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        // trailing comma before a brace
        send_item(CH_COMMA, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_RBRACE, 1'b0);
        // slash still held at end of text
        send_item(8'h61, 1'b0);
        send_item(CH_SLASH, 1'b1);
        // comma and whitespace still held at end of text
        send_item(CH_COMMA, 1'b0);
        send_item(CH_SPACE, 1'b1);
        // comma after a held comma
        send_item(CH_COMMA, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_RBRACK, 1'b1);
        wait_drained();

        // random fragments, with one stretch free of gaps and stalls
        while (items_sent < ITEMS_TOTAL)
        begin
            if (items_sent >= 150 && items_sent < 230)
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            else
            begin
                tx_idle_pct = 30;
                rx_idle_pct <= 30;
            end
            if (!mid_drain_done && items_sent >= 280)
            begin
                wait_drained();
                mid_drain_done = 1'b1;
            end
            build_fragment();
            send_run($urandom_range(11) == 0);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("** jsonc_comment_comma_stripper_core: PASSED **");
        else
            $display("** jsonc_comment_comma_stripper_core: FAILED **");
        $finish;
    end

endmodule
